### rtl/rlr_pkg.sv
// rlr_pkg: shared types, codes and interval helpers of the ring lookup router
// used by rlr_cfg_regs, rlr_route and ring_lookup_router
package rlr_pkg;

    localparam int KEY_BITS    = 6;
    localparam int FINGERS     = KEY_BITS;
    localparam int TABLE_W     = KEY_BITS * FINGERS;
    localparam int CFG_DATA_W  = TABLE_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CMD_W       = 2;
    localparam int ACTION_W    = 3;

    // message kinds
    localparam logic [CMD_W-1:0] CMD_ASK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LAST    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ANSWER  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // result actions
    localparam logic [ACTION_W-1:0] ACT_FORWARD   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LAST      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ANSWER    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NOT_FOUND = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REPORT    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ID       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_KEY    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FINGER_NODES = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FINGER_RANKS = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] partner;
    } msg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_BITS-1:0] dest_rank;
        logic [KEY_BITS-1:0] key_out;
        logic [KEY_BITS-1:0] second_word;
    } route_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] own_id;
        logic [KEY_BITS-1:0] first_key;
        logic [TABLE_W-1:0]  finger_nodes;
        logic [TABLE_W-1:0]  finger_ranks;
    } cfg_t;

    // key in circular (lo, hi]
    function automatic logic in_open_closed(logic [KEY_BITS-1:0] lo,
                                            logic [KEY_BITS-1:0] hi,
                                            logic [KEY_BITS-1:0] k);
        if (lo < hi)
            return (k > lo) && (k <= hi);
        return (k > lo) || (k <= hi);
    endfunction

    // key in circular [lo, hi]
    function automatic logic in_closed(logic [KEY_BITS-1:0] lo,
                                       logic [KEY_BITS-1:0] hi,
                                       logic [KEY_BITS-1:0] k);
        if (hi >= lo)
            return (k >= lo) && (k <= hi);
        return (k >= lo) || (k <= hi);
    endfunction

endpackage

### rtl/rlr_cfg_regs.sv
// rlr_cfg_regs: configuration registers of the ring lookup router
// depends on rlr_pkg
module rlr_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rlr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rlr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rlr_pkg::cfg_t                    cfg
);
    import rlr_pkg::*;

    logic [KEY_BITS-1:0] own_id_reg;
    logic [KEY_BITS-1:0] first_key_reg;
    logic [TABLE_W-1:0]  finger_nodes_reg;
    logic [TABLE_W-1:0]  finger_ranks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg       <= '0;
            first_key_reg    <= '0;
            finger_nodes_reg <= '0;
            finger_ranks_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_ID:       own_id_reg       <= cfg_data[KEY_BITS-1:0];
                REG_FIRST_KEY:    first_key_reg    <= cfg_data[KEY_BITS-1:0];
                REG_FINGER_NODES: finger_nodes_reg <= cfg_data[TABLE_W-1:0];
                REG_FINGER_RANKS: finger_ranks_reg <= cfg_data[TABLE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.own_id       = own_id_reg;
    assign cfg.first_key    = first_key_reg;
    assign cfg.finger_nodes = finger_nodes_reg;
    assign cfg.finger_ranks = finger_ranks_reg;

endmodule

### rtl/rlr_route.sv
// rlr_route: combinational routing decision for one message
// depends on rlr_pkg
module rlr_route (
    input  rlr_pkg::cfg_t   cfg,
    input  rlr_pkg::msg_t   msg,
    output logic            has_result,
    output rlr_pkg::route_t result
);
    import rlr_pkg::*;

    logic [FINGERS-1:0]  hit;
    logic                fwd_found;
    logic [KEY_BITS-1:0] fwd_rank;

    // all finger compares in parallel, the highest hit wins
    always_comb
    begin
        fwd_found = 1'b0;
        fwd_rank  = '0;
        for (int i = 0; i < FINGERS; i++)
        begin
            hit[i] = (cfg.finger_nodes[i*KEY_BITS +: KEY_BITS] != cfg.own_id) &&
                     in_open_closed(cfg.finger_nodes[i*KEY_BITS +: KEY_BITS],
                                    cfg.own_id, msg.key);
            if (hit[i])
            begin
                fwd_found = 1'b1;
                fwd_rank  = cfg.finger_ranks[i*KEY_BITS +: KEY_BITS];
            end
        end
    end

    always_comb
    begin
        has_result         = 1'b1;
        result.action      = ACT_REPORT;
        result.dest_rank   = '0;
        result.key_out     = msg.key;
        result.second_word = msg.partner;
        case (msg.cmd)
            CMD_ASK:
            begin
                if (fwd_found)
                begin
                    result.action    = ACT_FORWARD;
                    result.dest_rank = fwd_rank;
                end
                else
                begin
                    result.action    = ACT_LAST;
                    result.dest_rank = cfg.finger_ranks[KEY_BITS-1:0];
                end
            end
            CMD_LAST:
            begin
                if (in_closed(cfg.first_key, cfg.own_id, msg.key))
                begin
                    result.action      = ACT_ANSWER;
                    result.dest_rank   = msg.partner;
                    result.second_word = cfg.own_id;
                end
                else
                begin
                    result.action      = ACT_NOT_FOUND;
                    result.second_word = '0;
                end
            end
            CMD_ANSWER:
            begin
                result.action = ACT_REPORT;
            end
            default:
            begin
                // unknown kind: dropped
                has_result = 1'b0;
            end
        endcase
    end

endmodule

### rtl/ring_lookup_router.sv
// ring_lookup_router: top level, message register, decision logic, result register
// depends on rlr_pkg, rlr_cfg_regs, rlr_route
//
// Takes one message per clock while msg_stall is low and returns at most one
// routing result per message: the message is captured in an input register,
// decided by a single pass over the six finger compares and captured in the
// result register. A stalled result holds; the input register keeps
// taking a message as long as the result register can move, so the sustained
// rate is one message per cycle. A message of unknown kind (cmd 3) is taken
// and yields no result. Configuration writes take effect at once and are meant
// for idle periods only.
module ring_lookup_router (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rlr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rlr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             msg_valid,
    output logic                             msg_stall,
    input  rlr_pkg::msg_t                    msg,
    output logic                             route_valid,
    input  logic                             route_stall,
    output rlr_pkg::route_t                  route
);
    import rlr_pkg::*;

    cfg_t   cfg;
    logic   s1_vld_reg;
    msg_t   s1_msg_reg;
    logic   out_vld_reg;
    route_t out_reg;
    logic   dec_has_result;
    route_t dec_result;
    logic   out_ready;
    logic   s1_ready;

    rlr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlr_route u_route (
        .cfg        (cfg),
        .msg        (s1_msg_reg),
        .has_result (dec_has_result),
        .result     (dec_result)
    );

    assign out_ready = !out_vld_reg || !route_stall;
    assign s1_ready  = !s1_vld_reg || out_ready;
    assign msg_stall = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (s1_ready)
            s1_vld_reg <= msg_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && msg_valid)
            s1_msg_reg <= msg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_ready)
            out_vld_reg <= s1_vld_reg && dec_has_result;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_vld_reg && dec_has_result)
            out_reg <= dec_result;
    end

    assign route_valid = out_vld_reg;
    assign route       = out_reg;

`ifndef ASSERT_OFF
    // input side only backs up when the message register is occupied
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        msg_stall |-> s1_vld_reg)
        else $error("msg_stall raised with empty input register");

    // a transfer always lands in the input register
    a_transfer_captured: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && !msg_stall) |=> s1_vld_reg)
        else $error("transferred message not captured");

    // a known message moving on produces a result next cycle
    a_known_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && out_ready && s1_msg_reg.cmd != CMD_UNKNOWN) |=> route_valid)
        else $error("known message produced no result");

    // unknown kind never produces a result
    a_unknown_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && out_ready && s1_msg_reg.cmd == CMD_UNKNOWN) |=> !route_valid)
        else $error("unknown message produced a result");

    // nothing sent means no destination
    a_no_dest_when_local: assert property (@(posedge clk) disable iff (!rst_n)
        (route_valid && (route.action == ACT_NOT_FOUND || route.action == ACT_REPORT))
        |-> route.dest_rank == '0)
        else $error("local result carries a destination rank");
`endif

endmodule
